>>> sv/two_ray_midpoint_triangulation_top_defines.svh
// assertion macros for the two-ray midpoint triangulation block
// expects clk and rst in the scope of use; no other dependencies
`ifndef TWO_RAY_MIDPOINT_TRIANGULATION_TOP_DEFINES_SVH
`define TWO_RAY_MIDPOINT_TRIANGULATION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TRM_ASSERT_IMP(lbl, ante, cons, msg)
`define TRM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/trm_pkg.sv
// shared widths and latencies of the two-ray midpoint triangulation block
// no dependencies
package trm_pkg;
  localparam int NUM_W     = 100;
  localparam int DET_W     = 68;
  localparam int S_W       = 64;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 4;
  localparam int SQ_STEPS  = 33;
endpackage

>>> sv/trm_if.sv
// valid/ready channels of the two-ray midpoint triangulation block
// no dependencies
interface trm_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_a_x;
  logic signed [31:0] origin_a_y;
  logic signed [31:0] origin_a_z;
  logic signed [31:0] dir_a_x;
  logic signed [31:0] dir_a_y;
  logic signed [31:0] dir_a_z;
  logic signed [31:0] origin_b_x;
  logic signed [31:0] origin_b_y;
  logic signed [31:0] origin_b_z;
  logic signed [31:0] dir_b_x;
  logic signed [31:0] dir_b_y;
  logic signed [31:0] dir_b_z;

  modport source (
    output valid, origin_a_x, origin_a_y, origin_a_z, dir_a_x, dir_a_y, dir_a_z,
    output origin_b_x, origin_b_y, origin_b_z, dir_b_x, dir_b_y, dir_b_z,
    input  ready
  );
  modport sink (
    input  valid, origin_a_x, origin_a_y, origin_a_z, dir_a_x, dir_a_y, dir_a_z,
    input  origin_b_x, origin_b_y, origin_b_z, dir_b_x, dir_b_y, dir_b_z,
    output ready
  );
endinterface

interface trm_res_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] mid_x;
  logic signed [31:0] mid_y;
  logic signed [31:0] mid_z;
  logic        [31:0] separation;

  modport source (
    output valid, found, mid_x, mid_y, mid_z, separation,
    input  ready
  );
  modport sink (
    input  valid, found, mid_x, mid_y, mid_z, separation,
    output ready
  );
endinterface

>>> sv/trm_div.sv
// pipelined rounded signed divider, one quotient bit per stage, 64-bit saturated result
// depends on trm_pkg
module trm_div
  import trm_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DET_W-1:0] den,
  output logic signed [S_W-1:0]   quo
);

  logic [NUM_W-1:0] an_a;
  logic [63:0]      ad_a;
  logic             neg_a;
  logic [127:0]     nm_b;
  logic [63:0]      ad_b;
  logic             neg_b;

  logic [63:0] rem  [DIV_STEPS+1];
  logic [63:0] nlo  [DIV_STEPS+1];
  logic [63:0] q    [DIV_STEPS+1];
  logic [63:0] ad   [DIV_STEPS+1];
  logic        neg  [DIV_STEPS+1];
  logic        ovf  [DIV_STEPS+1];
  logic [64:0] trial [DIV_STEPS];
  logic        take  [DIV_STEPS];
  logic        sat;

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem[k], nlo[k][63]};
      take[k]  = trial[k] >= {1'b0, ad[k]};
    end
  end

  assign sat = ovf[DIV_STEPS] | q[DIV_STEPS][63];

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= num[NUM_W-1] ^ den[DET_W-1];
      an_a  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      ad_a  <= den[DET_W-1] ? 64'(-den) : 64'(den);

      neg_b <= neg_a;
      ad_b  <= ad_a;
      nm_b  <= 128'({an_a, 30'b0}) + 128'(ad_a >> 1);

      ovf[0] <= nm_b[127:64] >= ad_b;
      rem[0] <= nm_b[127:64];
      nlo[0] <= nm_b[63:0];
      q[0]   <= '0;
      ad[0]  <= ad_b;
      neg[0] <= neg_b;

      for (int k = 0; k < DIV_STEPS; k++) begin
        rem[k+1] <= take[k] ? 64'(trial[k] - {1'b0, ad[k]}) : trial[k][63:0];
        q[k+1]   <= {q[k][62:0], take[k]};
        nlo[k+1] <= {nlo[k][62:0], 1'b0};
        ad[k+1]  <= ad[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end

      if (neg[DIV_STEPS]) begin
        quo <= sat ? {1'b1, {(S_W-1){1'b0}}} : -$signed({1'b0, q[DIV_STEPS][62:0]});
      end else begin
        quo <= sat ? {1'b0, {(S_W-1){1'b1}}} : $signed({1'b0, q[DIV_STEPS][62:0]});
      end
    end
  end

endmodule

>>> sv/two_ray_midpoint_triangulation_top.sv
// two-ray midpoint triangulation, fully pipelined with a two-entry output queue
// path from input item to result valid: 7 front stages, 68 divider stages,
// 7 point/distance stages, 33 square-root stages and 1 queue stage, plus queue wait
// throughput: one item per cycle unless the output queue is full; the queue lets input
// flow while one result waits; rst (synchronous) empties only the pipeline and the queue
`include "two_ray_midpoint_triangulation_top_defines.svh"
module two_ray_midpoint_triangulation_top
  import trm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  trm_ray_if.sink  rays,
  trm_res_if.source result
);

  localparam int LAT_Q = 7 + DIV_LAT;
  localparam int LAT   = LAT_Q + 7 + SQ_STEPS;
  localparam logic signed [31:0]      DIR_ONE = 32'sd1073741824;
  localparam logic signed [DET_W-1:0] DET_MIN = DET_W'(1152921505);

  typedef struct packed {
    logic [2:0][31:0] oa;
    logic [2:0][31:0] ob;
    logic [2:0][31:0] da;
    logic [2:0][31:0] db;
  } side_t;

  typedef struct packed {
    logic             found;
    logic [2:0][31:0] mid;
    logic [31:0]      sep;
  } res_t;

  function automatic logic signed [31:0] clampdir(input logic signed [31:0] v);
    if (v > DIR_ONE) return DIR_ONE;
    if (v < -DIR_ONE) return -DIR_ONE;
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -37'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  logic        adv;
  logic [LAT:1] vld;
  side_t       in_sd;
  side_t       sd [1:LAT_Q];
  logic        ok_q [7:LAT];

  // front
  logic signed [32:0] gap1 [3];
  logic signed [63:0] aa2 [3], ab2 [3], bb2 [3];
  logic signed [64:0] qa2 [3], qb2 [3];
  logic signed [63:0] raa3, rab3, rbb3;
  logic signed [66:0] qa3, qb3;
  logic signed [63:0] raa_r, rab_r, rbb_r;
  logic signed [32:0] paa4, pab4, pbb4;
  logic signed [66:0] qa4, qb4;
  logic signed [32:0] p_sel [4];
  logic signed [66:0] q_sel [4];
  logic signed [65:0] dpp1, dpp2;
  logic signed [67:0] pp_lo5 [4];
  logic signed [65:0] pp_hi5 [4];
  logic signed [NUM_W-1:0] hx [4];
  logic signed [NUM_W-1:0] full6 [4];
  logic signed [DET_W-1:0] det6, det7;
  logic signed [NUM_W-1:0] na7, nb7;
  logic signed [S_W-1:0]   sa, sb;

  // back
  logic signed [64:0] pl1 [2][3];
  logic signed [63:0] ph1 [2][3];
  logic signed [31:0] org1 [2][3], org2 [2][3];
  logic signed [95:0] fp [2][3];
  logic signed [34:0] t2 [2][3];
  logic signed [35:0] c3 [2][3];
  logic signed [36:0] ms4 [3], df4 [3];
  logic signed [36:0] mh [3], mabs [3];
  logic        [2:0]  big5;
  logic [31:0]        m5 [3];
  logic [63:0]        sq6 [3];
  logic [2:0][31:0]   midq [LAT_Q+5:LAT];
  logic               bigq [LAT_Q+6:LAT];

  // square root
  logic [65:0] rm [SQ_STEPS+1];
  logic [32:0] rt [SQ_STEPS+1];
  logic [66:0] tr [SQ_STEPS];
  logic        sq_take [SQ_STEPS];
  logic        rup;
  logic [33:0] r1;
  res_t        res_d;

  // output queue
  res_t        fifo [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  logic        push, pop;

  assign adv        = cnt != 2'd2;
  assign rays.ready = adv;

  assign in_sd.oa[0] = rays.origin_a_x;
  assign in_sd.oa[1] = rays.origin_a_y;
  assign in_sd.oa[2] = rays.origin_a_z;
  assign in_sd.ob[0] = rays.origin_b_x;
  assign in_sd.ob[1] = rays.origin_b_y;
  assign in_sd.ob[2] = rays.origin_b_z;
  assign in_sd.da[0] = clampdir(rays.dir_a_x);
  assign in_sd.da[1] = clampdir(rays.dir_a_y);
  assign in_sd.da[2] = clampdir(rays.dir_a_z);
  assign in_sd.db[0] = clampdir(rays.dir_b_x);
  assign in_sd.db[1] = clampdir(rays.dir_b_y);
  assign in_sd.db[2] = clampdir(rays.dir_b_z);

  always_comb begin
    raa_r = raa3 + (64'sd1 <<< 29);
    rab_r = rab3 + (64'sd1 <<< 29);
    rbb_r = rbb3 + (64'sd1 <<< 29);
    // na = ab*qb - bb*qa, nb = aa*qb - ab*qa
    p_sel[0] = pab4;
    p_sel[1] = pbb4;
    p_sel[2] = paa4;
    p_sel[3] = pab4;
    q_sel[0] = qb4;
    q_sel[1] = qa4;
    q_sel[2] = qb4;
    q_sel[3] = qa4;
    for (int j = 0; j < 4; j++) begin
      hx[j] = NUM_W'(pp_hi5[j]);
    end
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < 3; i++) begin
        fp[r][i] = (96'(ph1[r][i]) <<< 32) + 96'(pl1[r][i]) + (96'sd1 <<< 59);
      end
    end
    for (int i = 0; i < 3; i++) begin
      mh[i]   = ms4[i] >>> 1;
      mabs[i] = df4[i][36] ? -df4[i] : df4[i];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      tr[k]      = (67'(rt[k]) << (SQ_STEPS - k)) + (67'd1 << (2 * (SQ_STEPS - 1 - k)));
      sq_take[k] = {1'b0, rm[k]} >= tr[k];
    end
  end

  trm_div u_div_a (
    .clk (clk),
    .en  (adv),
    .num (na7),
    .den (det7),
    .quo (sa)
  );

  trm_div u_div_b (
    .clk (clk),
    .en  (adv),
    .num (nb7),
    .den (det7),
    .quo (sb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], rays.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[1] <= in_sd;
      for (int k = 2; k <= LAT_Q; k++) sd[k] <= sd[k-1];
      for (int i = 0; i < 3; i++) begin
        gap1[i] <= 33'($signed(in_sd.oa[i])) - 33'($signed(in_sd.ob[i]));
        aa2[i]  <= 64'($signed(sd[1].da[i])) * 64'($signed(sd[1].da[i]));
        ab2[i]  <= 64'($signed(sd[1].da[i])) * 64'($signed(sd[1].db[i]));
        bb2[i]  <= 64'($signed(sd[1].db[i])) * 64'($signed(sd[1].db[i]));
        qa2[i]  <= 65'($signed(sd[1].da[i])) * 65'(gap1[i]);
        qb2[i]  <= 65'($signed(sd[1].db[i])) * 65'(gap1[i]);
      end
      raa3 <= aa2[0] + aa2[1] + aa2[2];
      rab3 <= ab2[0] + ab2[1] + ab2[2];
      rbb3 <= bb2[0] + bb2[1] + bb2[2];
      qa3  <= 67'(qa2[0]) + 67'(qa2[1]) + 67'(qa2[2]);
      qb3  <= 67'(qb2[0]) + 67'(qb2[1]) + 67'(qb2[2]);

      paa4 <= raa_r[62:30];
      pab4 <= rab_r[62:30];
      pbb4 <= rbb_r[62:30];
      qa4  <= qa3;
      qb4  <= qb3;

      dpp1 <= 66'(paa4) * 66'(pbb4);
      dpp2 <= 66'(pab4) * 66'(pab4);
      for (int j = 0; j < 4; j++) begin
        pp_lo5[j] <= 68'(p_sel[j]) * 68'($signed({1'b0, q_sel[j][33:0]}));
        pp_hi5[j] <= 66'(p_sel[j]) * 66'($signed(q_sel[j][66:34]));
      end

      for (int j = 0; j < 4; j++) full6[j] <= (hx[j] <<< 34) + NUM_W'(pp_lo5[j]);
      det6 <= DET_W'(dpp1) - DET_W'(dpp2);

      na7     <= full6[0] - full6[1];
      nb7     <= full6[2] - full6[3];
      det7    <= det6;
      ok_q[7] <= (det6 >= DET_MIN) || (det6 <= -DET_MIN);
      for (int k = 8; k <= LAT; k++) ok_q[k] <= ok_q[k-1];

      for (int i = 0; i < 3; i++) begin
        pl1[0][i]  <= 65'($signed(sd[LAT_Q].da[i])) * 65'($signed({1'b0, sa[31:0]}));
        ph1[0][i]  <= 64'($signed(sd[LAT_Q].da[i])) * 64'($signed(sa[63:32]));
        pl1[1][i]  <= 65'($signed(sd[LAT_Q].db[i])) * 65'($signed({1'b0, sb[31:0]}));
        ph1[1][i]  <= 64'($signed(sd[LAT_Q].db[i])) * 64'($signed(sb[63:32]));
        org1[0][i] <= $signed(sd[LAT_Q].oa[i]);
        org1[1][i] <= $signed(sd[LAT_Q].ob[i]);
      end
      for (int r = 0; r < 2; r++) begin
        for (int i = 0; i < 3; i++) begin
          t2[r][i]   <= fp[r][i][94:60];
          org2[r][i] <= org1[r][i];
          c3[r][i]   <= 36'(org2[r][i]) + 36'(t2[r][i]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        ms4[i] <= 37'(c3[0][i]) + 37'(c3[1][i]) + 37'sd1;
        df4[i] <= 37'(c3[0][i]) - 37'(c3[1][i]);
        midq[LAT_Q+5][i] <= sat32(mh[i]);
        big5[i] <= mabs[i][36:32] != 5'd0;
        m5[i]   <= mabs[i][31:0];
        sq6[i]  <= 64'(m5[i]) * 64'(m5[i]);
      end
      for (int k = LAT_Q + 6; k <= LAT; k++) midq[k] <= midq[k-1];
      bigq[LAT_Q+6] <= |big5;
      for (int k = LAT_Q + 7; k <= LAT; k++) bigq[k] <= bigq[k-1];

      rm[0] <= 66'(sq6[0]) + 66'(sq6[1]) + 66'(sq6[2]);
      rt[0] <= '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        rm[k+1] <= sq_take[k] ? 66'({1'b0, rm[k]} - tr[k]) : rm[k];
        rt[k+1] <= sq_take[k] ? (rt[k] | (33'd1 << (SQ_STEPS - 1 - k))) : rt[k];
      end
    end
  end

  assign rup = rm[SQ_STEPS] > 66'(rt[SQ_STEPS]);
  assign r1  = 34'(rt[SQ_STEPS]) + 34'(rup);

  always_comb begin
    res_d = '0;
    if (ok_q[LAT]) begin
      res_d.found = 1'b1;
      res_d.mid   = midq[LAT];
      if (bigq[LAT] || (r1[33:32] != 2'd0)) begin
        res_d.sep = 32'hFFFF_FFFF;
      end else begin
        res_d.sep = r1[31:0];
      end
    end
  end

  assign push = adv & vld[LAT];
  assign pop  = result.valid & result.ready;

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= res_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign result.valid      = cnt != 2'd0;
  assign result.found      = fifo[rp].found;
  assign result.mid_x      = fifo[rp].mid[0];
  assign result.mid_y      = fifo[rp].mid[1];
  assign result.mid_z      = fifo[rp].mid[2];
  assign result.separation = fifo[rp].sep;

  `TRM_ASSERT_IMP(a_cnt_range, 1'b1, cnt != 2'd3, "output queue count out of range")
  `TRM_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld), "pipeline moved while stalled")
  `TRM_ASSERT_IMP(a_miss_zero, result.valid && !result.found, result.mid_x == 0 && result.mid_y == 0 && result.mid_z == 0 && result.separation == 0, "parallel item with nonzero fields")

endmodule

>>> tb/tb_top.sv
// self-checking bench for the two-ray midpoint triangulation block
// drives ray pairs over trm_ray_if and checks trm_res_if items against a local predictor or table values
// depends on trm_pkg, trm_if.sv and two_ray_midpoint_triangulation_top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trm_pkg::*;

  localparam logic signed [31:0] ONE     = 32'sd1073741824;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam longint DET_MIN    = 64'd1152921505;
  localparam int     N_RANDOM   = 735;
  localparam int     CYCLE_CAP  = 400000;

  typedef logic signed [31:0] ray_pair_t [12];
  typedef struct packed {
    logic               found;
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [31:0] mid_z;
    logic        [31:0] separation;
  } tri_res_t;
  typedef struct {
    ray_pair_t pair;
    bit        known;
    tri_res_t  res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  trm_ray_if rays_if();
  trm_res_if res_if();

  two_ray_midpoint_triangulation_top u_top (
    .clk    (clk),
    .rst    (rst),
    .rays   (rays_if),
    .result (res_if)
  );

  always #10 clk = ~clk;

  stim_row_t stim_rows [16];
  int        n_rows = 0;
  tri_res_t  expected_results [1024];
  int        exp_wr = 0;
  int        exp_rd = 0;
  int        errors = 0;
  int        checked = 0;
  int        not_found = 0;
  int        send_idle = 8;
  int        recv_idle = 62;
  int        cycles = 0;

  function automatic logic signed [127:0] wide(longint v);
    return v;
  endfunction

  function automatic longint dir_clamp(logic signed [31:0] v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint sat64(logic signed [127:0] x);
    if (x[127:63] == {65{x[63]}}) return x[63:0];
    return x[127] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
  endfunction

  function automatic longint div_round(logic signed [127:0] n, logic signed [127:0] d);
    logic [127:0] an, ad, q;
    an = n[127] ? -n : n;
    ad = d[127] ? -d : d;
    q = (an + (ad >> 1)) / ad;
    if (n[127] != d[127]) q = -q;
    return sat64(q);
  endfunction

  function automatic longint closest_coord(longint org, longint dir, longint s);
    logic signed [127:0] p;
    p = wide(dir) * wide(s) + (128'sd1 <<< 59);
    return org + sat64(p >>> 60);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic tri_res_t triangulate(ray_pair_t p);
    longint oa[3], da[3], ob[3], db[3];
    longint raa, rab, rbb, paa, pab, pbb, sa, sb, ca, cb, m, gap;
    logic signed [127:0] qa, qb, det, adet, na, nb;
    logic [127:0] sum, mm, rr, t;
    logic big;
    logic signed [31:0] mids[3];
    tri_res_t r;
    r = '0;
    raa = 0; rab = 0; rbb = 0; qa = 0; qb = 0; sum = 0; big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      oa[i] = p[i];
      da[i] = dir_clamp(p[3 + i]);
      ob[i] = p[6 + i];
      db[i] = dir_clamp(p[9 + i]);
    end
    for (int i = 0; i < 3; i++) begin
      gap = oa[i] - ob[i];
      raa += da[i] * da[i];
      rab += da[i] * db[i];
      rbb += db[i] * db[i];
      qa += wide(da[i]) * wide(gap);
      qb += wide(db[i]) * wide(gap);
    end
    paa = (raa + (64'sd1 <<< 29)) >>> 30;
    pab = (rab + (64'sd1 <<< 29)) >>> 30;
    pbb = (rbb + (64'sd1 <<< 29)) >>> 30;
    det = wide(paa) * wide(pbb) - wide(pab) * wide(pab);
    adet = det[127] ? -det : det;
    if (adet < wide(DET_MIN)) return r;
    na = wide(pab) * qb - wide(pbb) * qa;
    nb = wide(paa) * qb - wide(pab) * qa;
    sa = div_round(na <<< 30, det);
    sb = div_round(nb <<< 30, det);
    for (int i = 0; i < 3; i++) begin
      ca = closest_coord(oa[i], da[i], sa);
      cb = closest_coord(ob[i], db[i], sb);
      mids[i] = sat32((ca + cb + 1) >>> 1);
      m = ca - cb;
      if (m < 0) m = -m;
      if (m > 64'sh00000000ffffffff) begin
        big = 1'b1;
      end else begin
        mm = m;
        sum += mm * mm;
      end
    end
    rr = 0;
    for (int b = 33; b >= 0; b--) begin
      t = rr | (128'd1 << b);
      if (sum >= t * t) rr = t;
    end
    if ((sum - rr * rr) > rr) rr++;
    r.found = 1'b1;
    r.mid_x = mids[0];
    r.mid_y = mids[1];
    r.mid_z = mids[2];
    r.separation = (big || rr > 128'hffffffff) ? 32'hffffffff : rr[31:0];
    return r;
  endfunction

  function automatic void add_row(ray_pair_t p, bit known, tri_res_t res);
    stim_row_t row;
    row.pair = p;
    row.known = known;
    row.res = res;
    stim_rows[n_rows] = row;
    n_rows++;
  endfunction

  function automatic logic signed [31:0] rand_dir();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? ONE : -ONE;
      default: return $signed($urandom_range(32'h80000000)) - ONE;
    endcase
  endfunction

  function automatic ray_pair_t random_pair();
    ray_pair_t p;
    int kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 12; i++) begin
      if (i % 6 < 3) begin
        p[i] = (kind < 60) ? $signed($urandom_range(200000)) - 100000 : $urandom;
      end else begin
        p[i] = rand_dir();
      end
    end
    if (kind >= 85) begin
      for (int i = 0; i < 3; i++) p[9 + i] = (kind >= 93) ? -p[3 + i] : p[3 + i];
    end
    return p;
  endfunction

  task automatic send_pair(ray_pair_t p);
    while ($urandom_range(99) < send_idle) begin
      rays_if.valid <= 1'b0;
      @(posedge clk);
    end
    rays_if.valid      <= 1'b1;
    rays_if.origin_a_x <= p[0];
    rays_if.origin_a_y <= p[1];
    rays_if.origin_a_z <= p[2];
    rays_if.dir_a_x    <= p[3];
    rays_if.dir_a_y    <= p[4];
    rays_if.dir_a_z    <= p[5];
    rays_if.origin_b_x <= p[6];
    rays_if.origin_b_y <= p[7];
    rays_if.origin_b_z <= p[8];
    rays_if.dir_b_x    <= p[9];
    rays_if.dir_b_y    <= p[10];
    rays_if.dir_b_z    <= p[11];
    @(posedge clk);
    while (!rays_if.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    tri_res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (exp_rd == exp_wr) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = expected_results[exp_rd];
        exp_rd++;
        checked++;
        if (!want.found) not_found++;
        if (res_if.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, res_if.found);
          errors++;
        end
        if (res_if.mid_x !== want.mid_x) begin
          $error("mid_x: expected %0d, got %0d", want.mid_x, res_if.mid_x);
          errors++;
        end
        if (res_if.mid_y !== want.mid_y) begin
          $error("mid_y: expected %0d, got %0d", want.mid_y, res_if.mid_y);
          errors++;
        end
        if (res_if.mid_z !== want.mid_z) begin
          $error("mid_z: expected %0d, got %0d", want.mid_z, res_if.mid_z);
          errors++;
        end
        if (res_if.separation !== want.separation) begin
          $error("separation: expected %0d, got %0d", want.separation, res_if.separation);
          errors++;
        end
      end
    end
    res_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    ray_pair_t p;
    tri_res_t  none;
    int        sent;
    none = '0;
    res_if.ready       = 1'b0;
    rays_if.valid      = 1'b0;
    rays_if.origin_a_x = '0;
    rays_if.origin_a_y = '0;
    rays_if.origin_a_z = '0;
    rays_if.dir_a_x    = '0;
    rays_if.dir_a_y    = '0;
    rays_if.dir_a_z    = '0;
    rays_if.origin_b_x = '0;
    rays_if.origin_b_y = '0;
    rays_if.origin_b_z = '0;
    rays_if.dir_b_x    = '0;
    rays_if.dir_b_y    = '0;
    rays_if.dir_b_z    = '0;

    // crossing rays, then skew rays 512 apart in z
    p = '{0, 0, 0, ONE, 0, 0, 100, -50, 0, 0, ONE, 0};
    add_row(p, 1'b1, '{1'b1, 100, 0, 0, 0});
    p = '{0, 0, 0, ONE, 0, 0, 100, -50, 512, 0, ONE, 0};
    add_row(p, 1'b1, '{1'b1, 100, 0, 256, 512});
    // parallel, antiparallel, zero directions, near-parallel
    p = '{0, 0, 0, ONE, 0, 0, 0, 300, 0, ONE, 0, 0};
    add_row(p, 1'b1, none);
    p = '{5, 6, 7, 0, ONE, 0, -9, 8, 1, 0, -ONE, 0};
    add_row(p, 1'b1, none);
    p = '{1, 2, 3, 0, 0, 0, 4, 5, 6, 0, 0, ONE};
    add_row(p, 1'b1, none);
    p = '{1, 2, 3, 0, 0, 0, 4, 5, 6, 0, 0, 0};
    add_row(p, 1'b1, none);
    p = '{0, 0, 0, ONE, 0, 0, 0, 9, 0, ONE, 1, 0};
    add_row(p, 1'b1, none);
    // origin extremes, out-of-range directions, near-parallel far crossings, diagonal directions
    p = '{S32_MIN, S32_MIN, S32_MIN, ONE, 0, 0, S32_MIN, S32_MIN, S32_MIN, 0, ONE, 0};
    add_row(p, 1'b0, none);
    p = '{S32_MAX, S32_MAX, S32_MAX, 0, 0, ONE, S32_MAX, S32_MAX, S32_MAX, ONE, 0, 0};
    add_row(p, 1'b0, none);
    p = '{S32_MAX, S32_MIN, S32_MAX, -ONE, 0, 0, S32_MIN, S32_MAX, S32_MIN, 0, -ONE, ONE};
    add_row(p, 1'b0, none);
    p = '{10, 20, 30, S32_MAX, 0, 0, -40, 50, -60, 0, S32_MIN, 0};
    add_row(p, 1'b0, none);
    p = '{0, 0, 0, S32_MIN, S32_MAX, S32_MIN, 0, 0, 0, S32_MAX, S32_MAX, S32_MAX};
    add_row(p, 1'b0, none);
    p = '{0, 0, 0, ONE, 0, 0, 0, 1000, 0, ONE, 2000000, 0};
    add_row(p, 1'b0, none);
    p = '{S32_MIN, 0, 0, ONE, 0, 0, S32_MAX, 1, 0, ONE, 60000, 7};
    add_row(p, 1'b0, none);
    p = '{-1, -1, -1, -ONE, -ONE, -ONE, 1, 1, 1, ONE, -ONE, ONE};
    add_row(p, 1'b0, none);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sent = 0;
    for (int n = 0; n < n_rows + N_RANDOM; n++) begin
      stim_row_t row;
      if (sent == 250) begin
        send_idle = 62;
        recv_idle = 8;
      end else if (sent == 500) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (n < n_rows) begin
        row = stim_rows[n];
      end else begin
        row.pair = random_pair();
        row.known = 1'b0;
      end
      send_pair(row.pair);
      expected_results[exp_wr] = row.known ? row.res : triangulate(row.pair);
      exp_wr++;
      sent++;
    end
    rays_if.valid <= 1'b0;

    while (exp_rd != exp_wr) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("sent %0d ray pairs (%0d table rows), checked %0d results, %0d not found",
             sent, n_rows, checked, not_found);
    $display("idle mixes: sender/receiver 8/62, 62/8 and 0/0; %0d mismatches", errors);
    if (errors == 0 && exp_rd == exp_wr) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
